// ===== hdl/ffrm_pkg.sv =====
// Shared constants, register and mode codes, and control types for the frame transform engine.
package ffrm_pkg;

  // Default sizes of the frame store and pixels
  localparam int MAX_DIM_DEF    = 256;
  localparam int MAX_PIXELS_DEF = 65536;
  localparam int PIXEL_BITS_DEF = 32;

  // Fixed field and register widths
  localparam int PIX_FIELD_W = 32;
  localparam int CFG_W       = 9;
  localparam int IDX_W       = 2;
  localparam int MODE_W      = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MODE   = 2'd2;

  // Transform modes
  localparam logic [MODE_W-1:0] MODE_COPY   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CW     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CCW    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIRROR = 3'd4;

  // Request function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EMIT = 1'b1;

  // Cycles the scan logic needs after reset or a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  // Store access control from the scan logic
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic last;
  } mem_ctl_t;

endpackage

// ===== hdl/ffrm_if.sv =====
// Request and result channel interfaces of the frame transform engine.
interface ffrm_req_if import ffrm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [PIX_FIELD_W-1:0] pixel_in;

  modport source (output valid, output func, output pixel_in, input ready);
  modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

interface ffrm_res_if import ffrm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [PIX_FIELD_W-1:0] pixel_out;
  logic                   frame_done;

  modport source (output valid, output pixel_out, output frame_done, input ready);
  modport sink   (input valid, input pixel_out, input frame_done, output ready);
endinterface

// ===== hdl/ffrm_store.sv =====
// Frame store memory with registered read data and the read-stage valid flag.
module ffrm_store import ffrm_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mem_ctl_t                      ctl,
  input  logic [$clog2(MAX_PIXELS)-1:0] addr,
  input  logic [PIXEL_BITS-1:0]         wr_data,
  input  logic                          take,
  output logic                          rd_valid,
  output logic                          rd_last,
  output logic [PIXEL_BITS-1:0]         rd_data
);

  logic [PIXEL_BITS-1:0] mem [MAX_PIXELS];

  // Single port: a load writes, an emit reads, never both in one cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
      rd_last <= ctl.last;
    end
  end

  // Read stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (ctl.rd_en) begin
      rd_valid <= 1'b1;
    end else if (take) begin
      rd_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/ffrm_scan.sv =====
// Configuration registers, load pointer and incremental output scan address generator.
module ffrm_scan import ffrm_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [IDX_W-1:0]              cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          go_load,
  input  logic                          go_emit,
  output logic                          busy,
  output mem_ctl_t                      ctl,
  output logic [$clog2(MAX_PIXELS)-1:0] addr
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PROD_W = 2 * DIM_W;
  localparam int ADDR_W = $clog2(MAX_PIXELS);

  logic [CFG_W-1:0]  frame_width;
  logic [CFG_W-1:0]  frame_height;
  logic [MODE_W-1:0] transform_mode;
  logic [1:0]        settle;
  logic              cfg_hit;

  logic [DIM_W-1:0]  w_clamp, h_clamp;
  logic [MODE_W-1:0] mode_norm;

  logic [DIM_W-1:0]  w_r, h_r;
  logic [MODE_W-1:0] mode_r;
  logic [PROD_W-1:0] total_r;

  logic [PROD_W-1:0] w_ext, total_m1, start, row_step, col_step;
  logic [DIM_W-1:0]  ow_m1, oh_m1;
  logic              quarter;

  logic [PROD_W-1:0] load_index;
  logic [DIM_W-1:0]  out_row, out_col;
  logic [PROD_W-1:0] row_base, scan_addr, row_base_next;
  logic              col_last, row_last;

  // Register writes; any valid index restarts loading and scanning
  assign cfg_hit = cfg_we &&
                   (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                    cfg_index == REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= CFG_W'(1);
      frame_height   <= CFG_W'(1);
      transform_mode <= MODE_COPY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  frame_width    <= cfg_data;
        REG_HEIGHT: frame_height   <= cfg_data;
        REG_MODE:   transform_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Settle counter: derived values are registered, then the scan restarts
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign busy = (settle != 2'd0);

  // Clamp dimensions, fold unknown modes onto copy
  always_comb begin
    if (frame_width == '0) begin
      w_clamp = DIM_W'(1);
    end else if (32'(frame_width) > MAX_DIM) begin
      w_clamp = DIM_W'(MAX_DIM);
    end else begin
      w_clamp = DIM_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_clamp = DIM_W'(1);
    end else if (32'(frame_height) > MAX_DIM) begin
      h_clamp = DIM_W'(MAX_DIM);
    end else begin
      h_clamp = DIM_W'(frame_height);
    end
    mode_norm = (transform_mode inside {[MODE_COPY:MODE_MIRROR]}) ? transform_mode : MODE_COPY;
  end

  // Derived geometry, one multiply per update
  always_ff @(posedge clk) begin
    w_r     <= w_clamp;
    h_r     <= h_clamp;
    mode_r  <= mode_norm;
    total_r <= PROD_W'(w_clamp) * PROD_W'(h_clamp);
  end

  // Scan start, step to the next row start and step along a row
  always_comb begin
    w_ext    = PROD_W'(w_r);
    total_m1 = total_r - PROD_W'(1);
    quarter  = (mode_r == MODE_CW) || (mode_r == MODE_CCW);
    ow_m1    = quarter ? h_r - DIM_W'(1) : w_r - DIM_W'(1);
    oh_m1    = quarter ? w_r - DIM_W'(1) : h_r - DIM_W'(1);
    case (mode_r)
      MODE_ROT180: begin
        start    = total_m1;
        row_step = -w_ext;
        col_step = -PROD_W'(1);
      end
      MODE_CW: begin
        start    = total_r - w_ext;
        row_step = PROD_W'(1);
        col_step = -w_ext;
      end
      MODE_CCW: begin
        start    = w_ext - PROD_W'(1);
        row_step = -PROD_W'(1);
        col_step = w_ext;
      end
      MODE_MIRROR: begin
        start    = w_ext - PROD_W'(1);
        row_step = w_ext;
        col_step = -PROD_W'(1);
      end
      default: begin
        start    = '0;
        row_step = w_ext;
        col_step = PROD_W'(1);
      end
    endcase
  end

  assign col_last      = (out_col == ow_m1);
  assign row_last      = (out_row == oh_m1);
  assign row_base_next = row_base + row_step;

  // Load pointer and output scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      out_row    <= '0;
      out_col    <= '0;
      row_base   <= '0;
      scan_addr  <= '0;
    end else if (busy) begin
      load_index <= '0;
      out_row    <= '0;
      out_col    <= '0;
      row_base   <= start;
      scan_addr  <= start;
    end else begin
      if (go_load) begin
        load_index <= (load_index == total_m1) ? '0 : load_index + PROD_W'(1);
      end
      if (go_emit) begin
        if (col_last) begin
          out_col <= '0;
          if (row_last) begin
            out_row   <= '0;
            row_base  <= start;
            scan_addr <= start;
          end else begin
            out_row   <= out_row + DIM_W'(1);
            row_base  <= row_base_next;
            scan_addr <= row_base_next;
          end
        end else begin
          out_col   <= out_col + DIM_W'(1);
          scan_addr <= scan_addr + col_step;
        end
      end
    end
  end

  // Store access
  always_comb begin
    ctl.wr_en = go_load;
    ctl.rd_en = go_emit;
    ctl.last  = col_last && row_last;
    addr      = go_load ? ADDR_W'(load_index) : ADDR_W'(scan_addr);
  end

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> busy)
    else $error("register write did not hold off requests");

  a_load_range: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (load_index <= total_m1))
    else $error("load pointer beyond frame");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (out_col <= ow_m1 && out_row <= oh_m1))
    else $error("output scan beyond frame");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (go_emit && ctl.last && !busy) |=>
      (out_row == '0 && out_col == '0 && scan_addr == start))
    else $error("scan did not return to frame start");

endmodule

// ===== hdl/frame_flip_rotate_mirror.sv =====
// Top level of the frame transform engine: request handshake, store, scan and result register.
//
//  channel   dir  handshake           payload
//  pix_req   in   valid/ready         func, pixel_in[31:0]
//  pix_res   out  valid/ready         pixel_out[31:0], frame_done
//  cfg       in   cfg_we (no ready)   cfg_index[1:0], cfg_data[8:0]
//
// One request per cycle unless held off or stalled; an emit reads the store when accepted,
// and the result enters the result register once it can take it; a load gives no result.
// After reset and after each register write, requests are held off while the frame geometry
// is registered and the scan restarts; the store is not cleared.
// A stalled result stops requests only once the read stage is also full.
module frame_flip_rotate_mirror import ffrm_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  ffrm_req_if.sink         pix_req,
  ffrm_res_if.source       pix_res,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_PIXELS);

  logic                  busy, accept, go_load, go_emit, take;
  mem_ctl_t              ctl;
  logic [ADDR_W-1:0]     addr;
  logic                  rd_valid, rd_last;
  logic [PIXEL_BITS-1:0] rd_data;

  logic                   out_valid;
  logic [PIX_FIELD_W-1:0] out_pixel;
  logic                   out_done;

  // Request handshake
  assign take          = rd_valid && (!out_valid || pix_res.ready);
  assign pix_req.ready = !busy && (!rd_valid || take);
  assign accept        = pix_req.valid && pix_req.ready;
  assign go_load       = accept && (pix_req.func == FUNC_LOAD);
  assign go_emit       = accept && (pix_req.func == FUNC_EMIT);

  ffrm_scan #(
    .MAX_DIM    (MAX_DIM),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go_load   (go_load),
    .go_emit   (go_emit),
    .busy      (busy),
    .ctl       (ctl),
    .addr      (addr)
  );

  ffrm_store #(
    .MAX_PIXELS (MAX_PIXELS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .addr     (addr),
    .wr_data  (PIXEL_BITS'(pix_req.pixel_in)),
    .take     (take),
    .rd_valid (rd_valid),
    .rd_last  (rd_last),
    .rd_data  (rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pix_res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_pixel <= PIX_FIELD_W'(rd_data);
      out_done  <= rd_last;
    end
  end

  assign pix_res.valid      = out_valid;
  assign pix_res.pixel_out  = out_pixel;
  assign pix_res.frame_done = out_done;

endmodule
